// File: sv/vrp_pkg.sv
`default_nettype none

package vrp_pkg;

  // Default build parameters.
  localparam int unsigned ANGLE_BITS       = 16;
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned COORD_FRAC_BITS  = 8;

  // Fixed field widths.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CENTER_W  = 11;
  localparam int unsigned FOCAL_W   = 10;
  localparam int unsigned OFFSET_W  = 10;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned SCR_W     = 13;

  // Datapath widths: table magnitude, signed trig value, multiplier operands,
  // wide accumulator, and quotient with one overflow bit.
  localparam int unsigned SIN_W  = 15;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned MA_W   = 48;
  localparam int unsigned MB_W   = 17;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned Q_W    = 14;
  localparam int unsigned CNT_W  = 4;

  // Sequencer step counts.
  localparam int unsigned LOOK_STEPS = 4;
  localparam int unsigned MUL_STEPS  = 10;
  localparam int unsigned DIV_STEPS  = Q_W;

  // pi/2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Reset values of the configuration registers.
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd240;
  localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 10'd300;
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 10'd400;
  localparam logic [STEP_W-1:0]   STEP_Y_RST   = 16'd522;
  localparam logic [STEP_W-1:0]   STEP_X_RST   = 16'd313;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_FOCAL    = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_STEP_Y   = 3'd4,
    REG_STEP_X   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // One quarter-wave table entry from its angle in Q30, by a truncated
  // Taylor series evaluated in Q30 and rounded to Q1.14.
  function automatic logic [SIN_W-1:0] sine_entry(input logic [63:0] th);
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    th2  = (th * th) >> 30;
    term = th;
    sum  = th;
    term = ((term * th2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * th2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * th2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * th2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * th2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * th2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * th2) >> 30) / 64'd210; sum = sum - term;
    term = ((term * th2) >> 30) / 64'd272; sum = sum + term;
    term = ((term * th2) >> 30) / 64'd342; sum = sum - term;
    v = (sum * 64'd16384 + (64'd1 << 29)) >> 30;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return v[SIN_W-1:0];
  endfunction

  // Clamp a screen coordinate to the signed 13-bit range.
  function automatic logic signed [SCR_W-1:0] sat_screen(input logic signed [15:0] v);
    logic signed [SCR_W-1:0] r;
    if (v > 16'sd4095) begin
      r = 13'sd4095;
    end else if (v < -16'sd4096) begin
      r = -13'sd4096;
    end else begin
      r = v[SCR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/vertex_rotate_project.sv
`default_nettype none

// Rotates a Q8.8 vertex about Y and then X and projects it in perspective.
// A frame beat (mode 1) advances both angle accumulators;
// it gives no result. A vertex beat runs four quarter-wave table reads, ten
// passes through one shared signed 48x17 multiplier with accumulator, and
// two 14-step restoring divisions on one shared compare-subtract unit; a
// result still held in the output register under stall makes it wait at the
// end. A vertex behind the viewer skips the divisions. in_stall_o is high
// while a vertex is being worked on. The user must write configuration through
// cfg_we_i only while idle; the block itself does not enforce this.
module vertex_rotate_project #(
  parameter int unsigned ANGLE_BITS       = vrp_pkg::ANGLE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = vrp_pkg::SINE_TABLE_DEPTH,
  parameter int unsigned COORD_FRAC_BITS  = vrp_pkg::COORD_FRAC_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [vrp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [vrp_pkg::CFG_W-1:0]            cfg_wdata_i,
  // Input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 mode_i,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]   vertex_x_i,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]   vertex_y_i,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]   vertex_z_i,
  // Output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [vrp_pkg::SCR_W-1:0]          screen_x_o,
  output logic signed [vrp_pkg::SCR_W-1:0]          screen_y_o,
  output logic                                      visible_o
);

  localparam int unsigned IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned RW    = ANGLE_BITS - 2;
  localparam int unsigned PIW   = RW + IW;
  localparam int unsigned OFF_SH = COORD_FRAC_BITS + 28;
  localparam int unsigned MA_W  = vrp_pkg::MA_W;
  localparam int unsigned MB_W  = vrp_pkg::MB_W;
  localparam int unsigned WW    = vrp_pkg::WIDE_W;
  localparam int unsigned Q_W   = vrp_pkg::Q_W;

  // Quarter-wave sine table, built at elaboration.
  logic [vrp_pkg::SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] TH = (64'(k) * vrp_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[k] = vrp_pkg::sine_entry(TH);
  end

  // Configuration and angle registers.
  logic [vrp_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic [vrp_pkg::FOCAL_W-1:0]  focal_q;
  logic [vrp_pkg::OFFSET_W-1:0] offset_q;
  logic [vrp_pkg::STEP_W-1:0]   step_y_q, step_x_q;
  logic [ANGLE_BITS-1:0]        ay_q, ax_q;

  vrp_pkg::state_e state_q, state_d;
  logic [vrp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic phase_y_q, phase_y_d;

  logic signed [vrp_pkg::COORD_W-1:0] vx_q, vy_q, vz_q;
  logic signed [vrp_pkg::TRIG_W-1:0]  sin_q [4];
  logic signed [WW-1:0]   acc_q, acc_d;
  logic signed [MA_W-1:0] x1_q, x1_d, z1_q, z1_d, y2_q, y2_d;
  logic signed [WW-1:0]   zz_q, zz_d, nx_q, nx_d, ny_q, ny_d;
  logic [WW-1:0]          rem_q, rem_d, den_q, den_d;
  logic [Q_W-1:0]         qt_q, qt_d;
  logic                   neg_q, neg_d;
  logic signed [vrp_pkg::SCR_W-1:0] rx_q, rx_d;

  logic out_valid_q, out_valid_d;
  logic signed [vrp_pkg::SCR_W-1:0] scr_x_q, scr_x_d, scr_y_q, scr_y_d;
  logic vis_q, vis_d;
  logic out_vis_q, out_vis_d;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Table lookup for the current step: sin/cos of Y, then of X.
  logic [ANGLE_BITS-1:0]    ang_sel;
  logic [1:0]               quad;
  logic [PIW-1:0]           idx_prod;
  logic [IW-1:0]            idx_raw, idx;
  logic [vrp_pkg::SIN_W-1:0] mag;
  logic signed [vrp_pkg::TRIG_W-1:0] trig;

  always_comb begin
    ang_sel  = cnt_q[1] ? ax_q : ay_q;
    quad     = ang_sel[ANGLE_BITS-1 -: 2] + {1'b0, cnt_q[0]};
    idx_prod = PIW'(ang_sel[RW-1:0]) * PIW'(SINE_TABLE_DEPTH);
    idx_raw  = IW'(idx_prod >> RW);
    idx      = quad[0] ? (IW'(SINE_TABLE_DEPTH) - idx_raw) : idx_raw;
    mag      = sine_rom[idx];
    trig     = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Shared multiplier operand selection.
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [MA_W+MB_W-1:0] mul_full;
  logic signed [WW-1:0]        prod;
  logic signed [MB_W-1:0]      focal_s;

  assign focal_s = MB_W'($signed({1'b0, focal_q}));

  always_comb begin
    unique case (cnt_q)
      4'd0:    begin mul_a = MA_W'(vx_q);         mul_b = MB_W'(sin_q[1]); end
      4'd1:    begin mul_a = MA_W'(vz_q);         mul_b = MB_W'(sin_q[0]); end
      4'd2:    begin mul_a = MA_W'(vx_q);         mul_b = MB_W'(sin_q[0]); end
      4'd3:    begin mul_a = MA_W'(vz_q);         mul_b = MB_W'(sin_q[1]); end
      4'd4:    begin mul_a = MA_W'(vy_q) <<< 14;  mul_b = MB_W'(sin_q[3]); end
      4'd5:    begin mul_a = z1_q;                mul_b = MB_W'(sin_q[2]); end
      4'd6:    begin mul_a = MA_W'(vy_q) <<< 14;  mul_b = MB_W'(sin_q[2]); end
      4'd7:    begin mul_a = z1_q;                mul_b = MB_W'(sin_q[3]); end
      4'd8:    begin mul_a = x1_q;                mul_b = focal_s;         end
      default: begin mul_a = y2_q;                mul_b = focal_s;         end
    endcase
    mul_full = mul_a * mul_b;
    prod     = $signed(mul_full[WW-1:0]);
  end

  // Shared compare-subtract unit of the divider.
  logic           div_ge;
  logic [WW-1:0]  rem_sub;
  logic [Q_W-1:0] qt_next;
  logic [Q_W-1:0] q_fin;
  logic [Q_W-1:0] q_mag;
  logic signed [Q_W:0]  q_s;
  logic signed [15:0]   scr_sum;
  logic [vrp_pkg::CENTER_W-1:0] center_sel;

  always_comb begin
    div_ge     = rem_q >= den_q;
    rem_sub    = rem_q - den_q;
    qt_next    = {qt_q[Q_W-2:0], div_ge};
    // Once the divisions are over, the quotient register holds the last result.
    q_fin      = (state_q == vrp_pkg::ST_DONE) ? qt_q : qt_next;
    q_mag      = q_fin[Q_W-1] ? (Q_W'(1) << (Q_W - 1)) : q_fin;
    q_s        = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    center_sel = phase_y_q ? center_y_q : center_x_q;
    scr_sum    = $signed(16'(center_sel)) + 16'(q_s);
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_y_d   = phase_y_q;
    acc_d       = acc_q;
    x1_d        = x1_q;
    z1_d        = z1_q;
    y2_d        = y2_q;
    zz_d        = zz_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    rem_d       = rem_q;
    den_d       = den_q;
    qt_d        = qt_q;
    neg_d       = neg_q;
    rx_d        = rx_q;
    scr_x_d     = scr_x_q;
    scr_y_d     = scr_y_q;
    vis_d       = vis_q;
    out_vis_d   = out_vis_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != vrp_pkg::ST_IDLE);

    unique case (state_q)
      vrp_pkg::ST_IDLE: begin
        if (in_acc && !mode_i) begin
          state_d = vrp_pkg::ST_LOOK;
          cnt_d   = '0;
        end
      end
      vrp_pkg::ST_LOOK: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == vrp_pkg::CNT_W'(vrp_pkg::LOOK_STEPS - 1)) begin
          state_d = vrp_pkg::ST_MUL;
          cnt_d   = '0;
        end
      end
      vrp_pkg::ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        unique case (cnt_q)
          4'd1:    x1_d = MA_W'(acc_q - prod);
          4'd3:    z1_d = MA_W'(acc_q + prod);
          4'd5:    y2_d = MA_W'(acc_q - prod);
          4'd7:    zz_d = acc_q + prod + ($signed(WW'(offset_q)) <<< OFF_SH);
          4'd8:    nx_d = prod <<< 14;
          4'd9:    ny_d = prod;
          default: acc_d = prod;
        endcase
        if (cnt_q == vrp_pkg::CNT_W'(vrp_pkg::MUL_STEPS - 1)) begin
          cnt_d = '0;
          if (zz_q > 0) begin
            state_d   = vrp_pkg::ST_DIV;
            phase_y_d = 1'b0;
            rem_d     = nx_q[WW-1] ? WW'(-nx_q) : WW'(nx_q);
            neg_d     = nx_q[WW-1];
            den_d     = WW'(zz_q) << (Q_W - 1);
            qt_d      = '0;
          end else begin
            state_d = vrp_pkg::ST_DONE;
            vis_d   = 1'b0;
          end
        end
      end
      vrp_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        qt_d  = qt_next;
        den_d = den_q >> 1;
        if (div_ge) begin
          rem_d = rem_sub;
        end
        if (cnt_q == vrp_pkg::CNT_W'(vrp_pkg::DIV_STEPS - 1)) begin
          cnt_d = '0;
          if (!phase_y_q) begin
            rx_d      = vrp_pkg::sat_screen(scr_sum);
            phase_y_d = 1'b1;
            rem_d     = ny_q[WW-1] ? WW'(-ny_q) : WW'(ny_q);
            neg_d     = ny_q[WW-1];
            den_d     = WW'(zz_q) << (Q_W - 1);
            qt_d      = '0;
          end else begin
            state_d = vrp_pkg::ST_DONE;
            vis_d   = 1'b1;
          end
        end
      end
      vrp_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_vis_d   = vis_q;
          state_d     = vrp_pkg::ST_IDLE;
          if (vis_q) begin
            scr_x_d = rx_q;
            scr_y_d = vrp_pkg::sat_screen(scr_sum);
          end else begin
            scr_x_d = '0;
            scr_y_d = '0;
          end
        end
      end
      default: state_d = vrp_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrp_pkg::ST_IDLE;
      cnt_q       <= '0;
      phase_y_q   <= 1'b0;
      out_valid_q <= 1'b0;
      vis_q       <= 1'b0;
      out_vis_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_y_q   <= phase_y_d;
      out_valid_q <= out_valid_d;
      vis_q       <= vis_d;
      out_vis_q   <= out_vis_d;
    end
  end

  // Configuration registers and angle accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= vrp_pkg::CENTER_X_RST;
      center_y_q <= vrp_pkg::CENTER_Y_RST;
      focal_q    <= vrp_pkg::FOCAL_RST;
      offset_q   <= vrp_pkg::OFFSET_RST;
      step_y_q   <= vrp_pkg::STEP_Y_RST;
      step_x_q   <= vrp_pkg::STEP_X_RST;
      ay_q       <= '0;
      ax_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vrp_pkg::REG_CENTER_X: center_x_q <= cfg_wdata_i[vrp_pkg::CENTER_W-1:0];
          vrp_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata_i[vrp_pkg::CENTER_W-1:0];
          vrp_pkg::REG_FOCAL:    focal_q    <= cfg_wdata_i[vrp_pkg::FOCAL_W-1:0];
          vrp_pkg::REG_OFFSET:   offset_q   <= cfg_wdata_i[vrp_pkg::OFFSET_W-1:0];
          vrp_pkg::REG_STEP_Y:   step_y_q   <= cfg_wdata_i;
          vrp_pkg::REG_STEP_X:   step_x_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc && mode_i) begin
        ay_q <= ay_q + ANGLE_BITS'(step_y_q);
        ax_q <= ax_q + ANGLE_BITS'(step_x_q);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && !mode_i) begin
      vx_q <= vertex_x_i;
      vy_q <= vertex_y_i;
      vz_q <= vertex_z_i;
    end
    if (state_q == vrp_pkg::ST_LOOK) begin
      sin_q[cnt_q[1:0]] <= trig;
    end
    acc_q   <= acc_d;
    x1_q    <= x1_d;
    z1_q    <= z1_d;
    y2_q    <= y2_d;
    zz_q    <= zz_d;
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    qt_q    <= qt_d;
    neg_q   <= neg_d;
    rx_q    <= rx_d;
    scr_x_q <= scr_x_d;
    scr_y_q <= scr_y_d;
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = scr_x_q;
  assign screen_y_o  = scr_y_q;
  assign visible_o   = out_vis_q;

endmodule

`default_nettype wire

// File: sv/vrp_checker.sv
`default_nettype none

module vrp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              mode_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [12:0]       screen_x_o,
  input wire logic [12:0]       screen_y_o,
  input wire logic              visible_o
);

  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A point behind the viewer lands on zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == 13'd0 && screen_y_o == 13'd0)
    else $error("hidden point has nonzero screen position");

  // A frame beat leaves the block free to take a beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> !in_stall_o)
    else $error("frame beat left the block busy");

  // A vertex beat keeps the block busy while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !mode_i |=> in_stall_o)
    else $error("vertex beat did not start the sequencer");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .screen_x_o  (screen_x_o),
  .screen_y_o  (screen_y_o),
  .visible_o   (visible_o)
);

`default_nettype wire
